>>> hw/rtl/irpd_pkg.sv
// irpd_pkg: shared types, timing windows and codes for the ir pulse width packet decoder
// no dependencies; imported by irpd_decode and ir_pulse_width_packet_decoder
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

    // timing window bounds, quarter milliseconds, exclusive on both sides
    localparam logic [7:0] T_3MS_LO  = 8'd10;
    localparam logic [7:0] T_3MS_HI  = 8'd14;
    localparam logic [7:0] T_6MS_LO  = 8'd22;
    localparam logic [7:0] T_6MS_HI  = 8'd26;
    localparam logic [7:0] T_1MS_LO  = 8'd2;
    localparam logic [7:0] T_2MS_LO  = 8'd6;
    localparam logic [7:0] T_END_GAP = 8'd14;
    localparam logic       ONE_BIT   = 1'b1;

    localparam int DATA_W = 9;

    // header kinds
    localparam logic [1:0] HDR_NONE   = 2'd0;
    localparam logic [1:0] HDR_NORMAL = 2'd1;
    localparam logic [1:0] HDR_BEACON = 2'd2;

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    // receiver phase, one-hot; a left shift steps to the next data bit
    typedef enum logic [10:0] {
        ST_PRE  = 11'b000_0000_0001,
        ST_SYNC = 11'b000_0000_0010,
        ST_BIT1 = 11'b000_0000_0100,
        ST_BIT2 = 11'b000_0000_1000,
        ST_BIT3 = 11'b000_0001_0000,
        ST_BIT4 = 11'b000_0010_0000,
        ST_BIT5 = 11'b000_0100_0000,
        ST_BIT6 = 11'b000_1000_0000,
        ST_BIT7 = 11'b001_0000_0000,
        ST_BIT8 = 11'b010_0000_0000,
        ST_BIT9 = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic       opcode;
        logic [7:0] mark_time;
        logic [7:0] space_time;
    } t_item;

    typedef struct packed {
        logic              packet_ready;
        logic [1:0]        header_kind;
        logic [3:0]        bit_total;
        logic [DATA_W-1:0] payload;
    } t_result;

    function automatic logic in_win(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (v > lo) && (v < hi);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ir_pulse_width_packet_decoder.sv
// ir_pulse_width_packet_decoder: top level, input register, decode core, result register
// depends on irpd_pkg and irpd_decode
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | tdata (low bit up)                          | tuser
// ----------+-----+---------------------------------------------+----------------
// s_axis    | in  | mark_time[7:0], space_time[15:8]            | opcode
// m_axis    | out | header_kind[1:0], bit_total[5:2],           | packet_ready
//           |     | payload[14:6], zero[15]                     |
//
// one word accepted per cycle while m_axis is not stalled, one result word per input word
// registered twice: input register, then decode into the result register
// the receiver state updates when a word moves from the input register to the result register
// a stall on m_axis holds the result register; the input register still takes one more word
// synchronous active-low reset clears the receiver and both valid flags

module ir_pulse_width_packet_decoder import irpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // mark_time[7:0], space_time[15:8]
    input  wire logic        s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // header_kind, bit_total, payload, pad
    output logic             m_axis_tuser    // packet_ready
);

    // input register
    logic    r_in_valid;
    t_item   r_in_item;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    step;
    t_result dec_result;

    // word leaves the input register when the result register is free or draining
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    irpd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.opcode     <= s_axis_tuser;
            r_in_item.mark_time  <= s_axis_tdata[7:0];
            r_in_item.space_time <= s_axis_tdata[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= dec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.packet_ready;
    assign m_axis_tdata  = {1'b0, r_out.payload, r_out.bit_total, r_out.header_kind};

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a buffered word is not dropped while the output stalls
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> r_in_valid)
        else $error("buffered word lost during output stall");

    // a delivered packet has a legal bit count and a header
    a_packet_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.bit_total != 4'd0) |->
        ((r_out.bit_total == 4'd5 || r_out.bit_total == 4'd7 ||
          r_out.bit_total == 4'd8 || r_out.bit_total == 4'd9) &&
         (r_out.header_kind == HDR_NORMAL || r_out.header_kind == HDR_BEACON)))
        else $error("malformed packet delivered");

endmodule

`default_nettype wire

>>> hw/rtl/irpd_decode.sv
// irpd_decode: receiver state and per-word decode, state updated on each processed word
// depends on irpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module irpd_decode import irpd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output t_result      o_result
);

    t_phase            r_phase, n_phase;
    logic              r_held, n_held;
    logic [DATA_W-1:0] r_shift, n_shift;
    logic [1:0]        r_kind, n_kind;
    logic [3:0]        r_count, n_count;

    logic              bit_val;
    logic              bit_ok;
    logic              may_end;
    logic [3:0]        bit_no;
    logic [DATA_W-1:0] shifted;

    // data bit number of the current phase, and whether a packet may end after it
    always_comb begin
        bit_no  = 4'd0;
        may_end = 1'b0;
        unique case (r_phase)
            ST_BIT1: bit_no = 4'd1;
            ST_BIT2: bit_no = 4'd2;
            ST_BIT3: bit_no = 4'd3;
            ST_BIT4: bit_no = 4'd4;
            ST_BIT5: begin bit_no = 4'd5; may_end = 1'b1; end
            ST_BIT6: bit_no = 4'd6;
            ST_BIT7: begin bit_no = 4'd7; may_end = 1'b1; end
            ST_BIT8: begin bit_no = 4'd8; may_end = 1'b1; end
            ST_BIT9: begin bit_no = 4'd9; may_end = 1'b1; end
            default: bit_no = 4'd0;
        endcase
    end

    always_comb begin
        bit_ok  = 1'b1;
        bit_val = 1'b0;
        if (in_win(i_item.mark_time, T_1MS_LO, T_2MS_LO)) begin
            bit_val = 1'b0;
        end else if (in_win(i_item.mark_time, T_2MS_LO, T_3MS_LO)) begin
            bit_val = ONE_BIT;
        end else begin
            bit_ok = 1'b0;
        end
    end

    assign shifted = {r_shift[DATA_W-2:0], bit_val};

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_shift  = r_shift;
        n_kind   = r_kind;
        n_count  = r_count;
        o_result = '0;

        if (i_item.opcode == OP_TAKE) begin
            if (r_held) begin
                o_result.packet_ready = 1'b1;
                o_result.header_kind  = r_kind;
                o_result.bit_total    = r_count;
                o_result.payload      = r_shift;
                n_held  = 1'b0;
                n_shift = '0;
                n_kind  = HDR_NONE;
                n_count = 4'd0;
            end
        end else begin
            if (!r_held) begin
                unique case (r_phase)
                    ST_PRE: begin
                        if (in_win(i_item.mark_time, T_3MS_LO, T_3MS_HI) &&
                            in_win(i_item.space_time, T_6MS_LO, T_6MS_HI)) begin
                            n_phase = ST_SYNC;
                        end
                    end
                    ST_SYNC: begin
                        priority if (in_win(i_item.mark_time, T_6MS_LO, T_6MS_HI) &&
                                     in_win(i_item.space_time, T_2MS_LO, T_3MS_LO)) begin
                            n_kind  = HDR_BEACON;
                            n_phase = ST_BIT1;
                        end else if (in_win(i_item.mark_time, T_3MS_LO, T_3MS_HI) &&
                                     in_win(i_item.space_time, T_2MS_LO, T_3MS_LO)) begin
                            n_kind  = HDR_NORMAL;
                            n_phase = ST_BIT1;
                        end else begin
                            n_phase = ST_PRE;
                            n_shift = '0;
                            n_kind  = HDR_NONE;
                            n_count = 4'd0;
                        end
                    end
                    ST_BIT1, ST_BIT2, ST_BIT3, ST_BIT4, ST_BIT5,
                    ST_BIT6, ST_BIT7, ST_BIT8, ST_BIT9: begin
                        priority if (bit_ok &&
                                     in_win(i_item.space_time, T_2MS_LO, T_3MS_LO) &&
                                     r_phase != ST_BIT9) begin
                            n_shift = shifted;
                            n_phase = t_phase'(r_phase << 1);
                        end else if (bit_ok && may_end &&
                                     i_item.space_time > T_END_GAP) begin
                            n_shift = shifted;
                            n_count = bit_no;
                            n_phase = ST_PRE;
                            n_held  = 1'b1;
                        end else begin
                            // bad timing, ninth-bit overrun included
                            n_phase = ST_PRE;
                            n_shift = '0;
                            n_kind  = HDR_NONE;
                            n_count = 4'd0;
                        end
                    end
                    default: n_phase = ST_PRE;
                endcase
            end
            o_result.packet_ready = n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_PRE;
            r_held  <= 1'b0;
            r_shift <= '0;
            r_kind  <= HDR_NONE;
            r_count <= 4'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_shift <= n_shift;
            r_kind  <= n_kind;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire
